[rtl/core/nti_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nti_pkg: shared types and codes
// Transaction payload structs and status codes of the name to id table.
// ----------------------------------------------------------------------------
package nti_pkg;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_NOT_FOUND = 2'd1;
   localparam logic [1:0] ST_FULL      = 2'd2;
   localparam logic [1:0] ST_TOO_LONG  = 2'd3;

   localparam logic KIND_LOOKUP   = 1'b0;
   localparam logic KIND_REGISTER = 1'b1;

   localparam int BYTES_PER_WORD = 8;

   typedef struct packed {
      logic       func;
      logic [7:0] name_char;
      logic       name_last;
      logic [7:0] task_id;
   } req_type;

   typedef struct packed {
      logic       kind;
      logic [1:0] status;
      logic [7:0] found_id;
   } rsp_type;

endpackage

[rtl/core/nti_namebuf.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nti_namebuf: received name buffer
// Holds the bytes of the incoming name and presents them as 64-bit words.
// ----------------------------------------------------------------------------
module nti_namebuf
   import nti_pkg::*;
#(
   parameter int MaxNameLen = 32,
   parameter int PosW       = 6,
   parameter int WordIdxW   = 2
) (
   input  logic                clock,
   input  logic                wr_en,
   input  logic [PosW-1:0]     wr_pos,
   input  logic [7:0]          wr_byte,
   input  logic [WordIdxW-1:0] rd_word,
   output logic [63:0]         rd_data
);

   logic [7:0] bytes_ff [MaxNameLen];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         bytes_ff[wr_pos[$clog2(MaxNameLen)-1:0]] <= wr_byte;
      end
   end

   // assemble the word; bytes past the slot read as zero
   always_comb begin
      int idx;
      for (int b = 0; b < BYTES_PER_WORD; b++) begin
         idx = int'(rd_word) * BYTES_PER_WORD + b;
         if (idx < MaxNameLen) begin
            rd_data[b*8 +: 8] = bytes_ff[idx[$clog2(MaxNameLen)-1:0]];
         end else begin
            rd_data[b*8 +: 8] = 8'h00;
         end
      end
   end

endmodule

[rtl/core/nti_mem.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nti_mem: entry storage
// Name word memory and length/id memory, both with registered reads.
// ----------------------------------------------------------------------------
module nti_mem #(
   parameter int NameDepth = 512,
   parameter int NameAw    = 9,
   parameter int MetaDepth = 128,
   parameter int MetaAw    = 7,
   parameter int MetaW     = 14
) (
   input  logic              clock,
   input  logic              name_rd_en,
   input  logic [NameAw-1:0] name_rd_addr,
   output logic [63:0]       name_rd_data,
   input  logic              name_wr_en,
   input  logic [NameAw-1:0] name_wr_addr,
   input  logic [63:0]       name_wr_data,
   input  logic              meta_rd_en,
   input  logic [MetaAw-1:0] meta_rd_addr,
   output logic [MetaW-1:0]  meta_rd_data,
   input  logic              meta_wr_en,
   input  logic [MetaAw-1:0] meta_wr_addr,
   input  logic [MetaW-1:0]  meta_wr_data
);

   logic [63:0]      name_mem [NameDepth];
   logic [MetaW-1:0] meta_mem [MetaDepth];

   always_ff @(posedge clock) begin
      if (name_wr_en) begin
         name_mem[name_wr_addr] <= name_wr_data;
      end
      if (name_rd_en) begin
         name_rd_data <= name_mem[name_rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (meta_wr_en) begin
         meta_mem[meta_wr_addr] <= meta_wr_data;
      end
      if (meta_rd_en) begin
         meta_rd_data <= meta_mem[meta_rd_addr];
      end
   end

endmodule

[rtl/core/name_to_id_table_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// name_to_id_table_core: name to task id table
// Bytes of a name arrive one per transaction; the final byte triggers a
// lookup or register against the stored entries and produces one result.
// ----------------------------------------------------------------------------
// Operation: name bytes are taken while idle; after the final byte, a
//   search reads one name word per cycle from the name memory, then an
//   append copies the name words of a new entry or an update rewrites an
//   id, and the result is loaded once the output register frees up.
// Throughput: one request at a time; no byte of a new name is accepted
//   until the result of the last one is loaded.
// Reset: synchronous, active high; clears entry count and receive state.
//   The memories need no clearing pass.
module name_to_id_table_core
   import nti_pkg::*;
#(
   parameter int MAX_ENTRIES  = 128,
   parameter int MAX_NAME_LEN = 32
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   localparam int W      = (MAX_NAME_LEN + BYTES_PER_WORD - 1) / BYTES_PER_WORD;
   localparam int WIW    = (W > 1) ? $clog2(W) : 1;
   localparam int EW     = $clog2(MAX_ENTRIES);
   localparam int CW     = $clog2(MAX_ENTRIES + 1);
   localparam int LW     = $clog2(MAX_NAME_LEN + 1);
   localparam int AW     = $clog2(MAX_ENTRIES * W);
   localparam int MW     = LW + 8;

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_SCAN  = 2'd1;
   localparam logic [1:0] S_WRITE = 2'd2;
   localparam logic [1:0] S_RESP  = 2'd3;

   logic [1:0]     state_ff, state_in;
   logic [CW-1:0]  count_ff, count_in;
   logic [LW-1:0]  pos_ff, pos_in;
   logic           long_ff, long_in;
   logic           func_ff, func_in;
   logic [7:0]     id_ff, id_in;
   logic [LW-1:0]  len_ff, len_in;
   logic [1:0]     status_ff, status_in;
   logic [7:0]     found_ff, found_in;
   logic [EW-1:0]  iss_e_ff, iss_e_in;
   logic [WIW-1:0] iss_w_ff, iss_w_in;
   logic           iss_on_ff, iss_on_in;
   logic           d_valid_ff, d_valid_in;
   logic [EW-1:0]  d_e_ff, d_e_in;
   logic [WIW-1:0] d_w_ff, d_w_in;
   logic           acc_ff, acc_in;
   logic [EW-1:0]  hit_e_ff, hit_e_in;
   logic           wr_new_ff, wr_new_in;
   logic [WIW-1:0] wr_w_ff, wr_w_in;
   logic           rsp_valid_ff, rsp_valid_in;
   rsp_type        rsp_ff, rsp_in;

   logic           req_ok;
   logic [LW-1:0]  flen;
   logic           ftl;
   logic [WIW-1:0] buf_rd_word;
   logic [63:0]    buf_word;
   logic [63:0]    name_rd_data;
   logic [MW-1:0]  meta_rd_data;
   logic           name_wr_en, meta_wr_en;
   logic [AW-1:0]  name_wr_addr;
   logic [EW-1:0]  meta_wr_addr;
   logic           word_eq;
   logic           acc_new;
   logic [EW-1:0]  last_e;

   assign req_ready = (state_ff == S_IDLE);
   assign req_ok    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign last_e    = EW'(count_ff - CW'(1));

   // final length and overflow including the byte of this transaction
   assign flen = (pos_ff < LW'(MAX_NAME_LEN)) ? pos_ff + LW'(1) : pos_ff;
   assign ftl  = long_ff || (pos_ff == LW'(MAX_NAME_LEN));

   assign buf_rd_word = (state_ff == S_WRITE) ? wr_w_ff : d_w_ff;

   nti_namebuf #(
      .MaxNameLen (MAX_NAME_LEN),
      .PosW       (LW),
      .WordIdxW   (WIW)
   ) u_namebuf (
      .clock   (clock),
      .wr_en   (req_ok && (pos_ff < LW'(MAX_NAME_LEN))),
      .wr_pos  (pos_ff),
      .wr_byte (req_data.name_char),
      .rd_word (buf_rd_word),
      .rd_data (buf_word)
   );

   assign name_wr_en   = (state_ff == S_WRITE) && wr_new_ff;
   assign name_wr_addr = AW'(count_ff) * AW'(W) + AW'(wr_w_ff);
   assign meta_wr_en   = (state_ff == S_WRITE) && (!wr_new_ff || (wr_w_ff == WIW'(0)));
   assign meta_wr_addr = wr_new_ff ? EW'(count_ff) : hit_e_ff;

   nti_mem #(
      .NameDepth (MAX_ENTRIES * W),
      .NameAw    (AW),
      .MetaDepth (MAX_ENTRIES),
      .MetaAw    (EW),
      .MetaW     (MW)
   ) u_mem (
      .clock        (clock),
      .name_rd_en   (iss_on_ff),
      .name_rd_addr (AW'(iss_e_ff) * AW'(W) + AW'(iss_w_ff)),
      .name_rd_data (name_rd_data),
      .name_wr_en   (name_wr_en),
      .name_wr_addr (name_wr_addr),
      .name_wr_data (buf_word),
      .meta_rd_en   (iss_on_ff),
      .meta_rd_addr (iss_e_ff),
      .meta_rd_data (meta_rd_data),
      .meta_wr_en   (meta_wr_en),
      .meta_wr_addr (meta_wr_addr),
      .meta_wr_data ({len_ff, id_ff})
   );

   // compare one returned word, ignoring bytes past the name length
   always_comb begin
      int idx;
      word_eq = 1'b1;
      for (int b = 0; b < BYTES_PER_WORD; b++) begin
         idx = int'(d_w_ff) * BYTES_PER_WORD + b;
         if (idx < int'(len_ff) && name_rd_data[b*8 +: 8] != buf_word[b*8 +: 8]) begin
            word_eq = 1'b0;
         end
      end
   end

   assign acc_new = ((d_w_ff == WIW'(0)) ? 1'b1 : acc_ff) && word_eq;

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      pos_in       = pos_ff;
      long_in      = long_ff;
      func_in      = func_ff;
      id_in        = id_ff;
      len_in       = len_ff;
      status_in    = status_ff;
      found_in     = found_ff;
      iss_e_in     = iss_e_ff;
      iss_w_in     = iss_w_ff;
      iss_on_in    = iss_on_ff;
      d_valid_in   = 1'b0;
      d_e_in       = iss_e_ff;
      d_w_in       = iss_w_ff;
      acc_in       = acc_ff;
      hit_e_in     = hit_e_ff;
      wr_new_in    = wr_new_ff;
      wr_w_in      = wr_w_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_ok) begin
               pos_in  = flen;
               long_in = ftl;
               if (req_data.name_last) begin
                  // final byte: latch request and pick the path
                  pos_in    = '0;
                  long_in   = 1'b0;
                  func_in   = req_data.func;
                  id_in     = req_data.task_id;
                  len_in    = flen;
                  found_in  = 8'h00;
                  iss_e_in  = '0;
                  iss_w_in  = '0;
                  wr_w_in   = '0;
                  wr_new_in = 1'b1;
                  if (ftl) begin
                     status_in = ST_TOO_LONG;
                     state_in  = S_RESP;
                  end else if (req_data.func == KIND_REGISTER &&
                               count_ff == CW'(MAX_ENTRIES)) begin
                     status_in = ST_FULL;
                     state_in  = S_RESP;
                  end else if (count_ff == '0) begin
                     if (req_data.func == KIND_LOOKUP) begin
                        status_in = ST_NOT_FOUND;
                        state_in  = S_RESP;
                     end else begin
                        status_in = ST_OK;
                        state_in  = S_WRITE;
                     end
                  end else begin
                     iss_on_in = 1'b1;
                     state_in  = S_SCAN;
                  end
               end
            end
         end
         S_SCAN: begin
            // issue reads: one name word per cycle
            if (iss_on_ff) begin
               d_valid_in = 1'b1;
               if (iss_w_ff == WIW'(W - 1)) begin
                  iss_w_in = '0;
                  iss_e_in = iss_e_ff + EW'(1);
                  if (iss_e_ff == last_e) begin
                     iss_on_in = 1'b0;
                  end
               end else begin
                  iss_w_in = iss_w_ff + WIW'(1);
               end
            end
            // check returned words
            if (d_valid_ff) begin
               acc_in = acc_new;
               if (d_w_ff == WIW'(W - 1)) begin
                  if (acc_new && meta_rd_data[MW-1:8] == len_ff) begin
                     iss_on_in  = 1'b0;
                     d_valid_in = 1'b0;
                     hit_e_in   = d_e_ff;
                     status_in  = ST_OK;
                     if (func_ff == KIND_LOOKUP) begin
                        found_in = meta_rd_data[7:0];
                        state_in = S_RESP;
                     end else begin
                        wr_new_in = 1'b0;
                        state_in  = S_WRITE;
                     end
                  end else if (d_e_ff == last_e) begin
                     if (func_ff == KIND_LOOKUP) begin
                        status_in = ST_NOT_FOUND;
                        state_in  = S_RESP;
                     end else begin
                        status_in = ST_OK;
                        state_in  = S_WRITE;
                     end
                  end
               end
            end
         end
         S_WRITE: begin
            // append copies all name words; update rewrites the id only
            if (!wr_new_ff) begin
               state_in = S_RESP;
            end else if (wr_w_ff == WIW'(W - 1)) begin
               count_in = count_ff + CW'(1);
               state_in = S_RESP;
            end else begin
               wr_w_in = wr_w_ff + WIW'(1);
            end
         end
         S_RESP: begin
            // load the result once the output register frees up
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in    = 1'b1;
               rsp_in.kind     = func_ff;
               rsp_in.status   = status_ff;
               rsp_in.found_id = found_ff;
               state_in        = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         pos_ff       <= '0;
         long_ff      <= 1'b0;
         iss_on_ff    <= 1'b0;
         d_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         pos_ff       <= pos_in;
         long_ff      <= long_in;
         iss_on_ff    <= iss_on_in;
         d_valid_ff   <= d_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff   <= func_in;
      id_ff     <= id_in;
      len_ff    <= len_in;
      status_ff <= status_in;
      found_ff  <= found_in;
      iss_e_ff  <= iss_e_in;
      iss_w_ff  <= iss_w_in;
      d_e_ff    <= d_e_in;
      d_w_ff    <= d_w_in;
      acc_ff    <= acc_in;
      hit_e_ff  <= hit_e_in;
      wr_new_ff <= wr_new_in;
      wr_w_ff   <= wr_w_in;
      rsp_ff    <= rsp_in;
   end

`ifndef SYNTHESIS
   a_count_max: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_ENTRIES))
      else $error("entry count above table size");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> (count_ff == $past(count_ff)) || (count_ff == $past(count_ff) + CW'(1)))
      else $error("entry count jumped");

   a_scan_nonempty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN) |-> (count_ff != '0))
      else $error("scan on empty table");

   a_pos_max: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= LW'(MAX_NAME_LEN))
      else $error("name position above slot size");
`endif

endmodule

[test/name_to_id_table_core_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// name_to_id_table_core_test: self-checking bench for the name to id table
// Streams names one byte per transaction, predicts each lookup or register
// result with a local table model and compares every response field.
// ----------------------------------------------------------------------------
module name_to_id_table_core_test;
   import nti_pkg::*;

   localparam int ENTRIES  = 128;
   localparam int NAME_LEN = 32;
   localparam int WATCHDOG_LIMIT = 20000;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;

   // Local copy of the table contents
   logic [7:0] tbl_name[ENTRIES][NAME_LEN];
   int         tbl_len[ENTRIES];
   logic [7:0] tbl_id[ENTRIES];
   int         tbl_count;
   logic [7:0] name_buf[NAME_LEN];
   int         name_pos;
   bit         name_overflow;

   rsp_type    expected_rsp_q[$];
   int         error_count;
   int         idle_cycles;
   int         send_idle_pct;
   int         recv_stall_pct;

   // Names reused by the random phase so lookups and updates hit
   logic [7:0] known_names[$][$];

   name_to_id_table_core #(
      .MAX_ENTRIES (ENTRIES),
      .MAX_NAME_LEN(NAME_LEN)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data)
   );

   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   // Return the index of the first stored entry equal to the buffered name
   function automatic int find_name();
      bit same;
      for (int i = 0; i < tbl_count; i++) begin
         if (tbl_len[i] == name_pos) begin
            same = 1'b1;
            for (int j = 0; j < name_pos; j++) begin
               if (tbl_name[i][j] != name_buf[j]) begin
                  same = 1'b0;
               end
            end
            if (same) begin
               return i;
            end
         end
      end
      return -1;
   endfunction

   // Advance the table model by one accepted byte; queue a result on the last
   task automatic predict_table(input req_type r);
      rsp_type res;
      int      hit;
      if (name_pos < NAME_LEN) begin
         name_buf[name_pos] = r.name_char;
         name_pos++;
      end else begin
         name_overflow = 1'b1;
      end
      if (r.name_last) begin
         res.kind     = r.func;
         res.found_id = 8'd0;
         if (name_overflow) begin
            res.status = ST_TOO_LONG;
         end else if (r.func == KIND_LOOKUP) begin
            hit = find_name();
            if (hit >= 0) begin
               res.status   = ST_OK;
               res.found_id = tbl_id[hit];
            end else begin
               res.status = ST_NOT_FOUND;
            end
         end else if (tbl_count >= ENTRIES) begin
            res.status = ST_FULL;
         end else begin
            hit = find_name();
            if (hit >= 0) begin
               tbl_id[hit] = r.task_id;
            end else begin
               for (int j = 0; j < name_pos; j++) begin
                  tbl_name[tbl_count][j] = name_buf[j];
               end
               tbl_len[tbl_count] = name_pos;
               tbl_id[tbl_count]  = r.task_id;
               tbl_count++;
            end
            res.status = ST_OK;
         end
         expected_rsp_q.push_back(res);
         name_pos      = 0;
         name_overflow = 1'b0;
      end
   endtask

   // Drive one transaction and hold it until accepted; start and end at a falling edge
   task automatic send_byte(input logic func, input logic [7:0] ch, input logic last,
                            input logic [7:0] id);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         req_data  <= req_type'($urandom);
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= '{func: func, name_char: ch, name_last: last, task_id: id};
      do begin
         @(posedge clock);
      end while (!req_ready);
      predict_table('{func: func, name_char: ch, name_last: last, task_id: id});
      @(negedge clock);
   endtask

   // Send a whole name; earlier bytes carry random kind and id to prove they are ignored
   task automatic send_name(input logic func, input logic [7:0] nm[$], input logic [7:0] id);
      for (int i = 0; i < nm.size(); i++) begin
         if (i == nm.size() - 1) begin
            send_byte(func, nm[i], 1'b1, id);
         end else begin
            send_byte(1'($urandom), nm[i], 1'b0, 8'($urandom));
         end
      end
   endtask

   function automatic void random_name(output logic [7:0] nm[$], input int len);
      nm = {};
      for (int i = 0; i < len; i++) begin
         nm.push_back(8'($urandom));
      end
   endfunction

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (expected_rsp_q.size() != 0) begin
         @(negedge clock);
      end
      repeat (20) @(negedge clock);
   endtask

   // Response side: stall at random and compare each transaction
   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_rsp_q.size() == 0) begin
            $display("%0t: unexpected response %p", $time, rsp_data);
            error_count++;
         end else begin
            want = expected_rsp_q.pop_front();
            if (rsp_data.kind !== want.kind) begin
               $display("%0t: kind expected %0d actual %0d", $time, want.kind,
                        rsp_data.kind);
               error_count++;
            end
            if (rsp_data.status !== want.status) begin
               $display("%0t: status expected %0d actual %0d", $time, want.status,
                        rsp_data.status);
               error_count++;
            end
            if (rsp_data.found_id !== want.found_id) begin
               $display("%0t: found_id expected %0d actual %0d", $time, want.found_id,
                        rsp_data.found_id);
               error_count++;
            end
         end
      end
   end

   // Watchdog: count cycles in which no transaction is accepted
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
         end
      end
   end

   // Directed: extremes, both kinds, not found, update, zero byte, too long
   task automatic test_directed();
      logic [7:0] nm[$];
      nm = {8'h00};
      send_name(KIND_LOOKUP, nm, 8'hFF);
      send_name(KIND_REGISTER, nm, 8'hFF);
      send_name(KIND_LOOKUP, nm, 8'h00);
      nm = {8'hFF};
      send_name(KIND_LOOKUP, nm, 8'h00);
      send_name(KIND_REGISTER, nm, 8'h00);
      send_name(KIND_REGISTER, nm, 8'hA5);
      send_name(KIND_LOOKUP, nm, 8'h00);
      nm = {8'hFF, 8'h00};
      send_name(KIND_LOOKUP, nm, 8'h00);
      random_name(nm, NAME_LEN);
      send_name(KIND_REGISTER, nm, 8'h5A);
      send_name(KIND_LOOKUP, nm, 8'h00);
      nm.push_back(8'h33);
      send_name(KIND_REGISTER, nm, 8'h11);
      send_name(KIND_LOOKUP, nm, 8'h11);
   endtask

   // Random names of mostly short length, biased to reuse earlier names
   task automatic test_random(input int byte_budget);
      logic [7:0] nm[$];
      int         sent;
      int         pick;
      sent = 0;
      while (sent < byte_budget) begin
         pick = $urandom_range(99);
         if (pick < 50 && known_names.size() != 0) begin
            nm = known_names[$urandom_range(known_names.size() - 1)];
         end else if (pick < 55) begin
            random_name(nm, NAME_LEN + $urandom_range(1, 3));
         end else begin
            random_name(nm, ($urandom_range(9) == 0) ? $urandom_range(1, NAME_LEN)
                                                      : $urandom_range(1, 4));
            if (nm.size() <= NAME_LEN) begin
               known_names.push_back(nm);
            end
         end
         send_name(1'($urandom), nm, 8'($urandom));
         sent += nm.size();
      end
   endtask

   // Fill the table to capacity, then hit the full case with new and stored names
   task automatic test_full();
      logic [7:0] nm[$];
      while (tbl_count < ENTRIES) begin
         random_name(nm, $urandom_range(1, 3));
         send_name(KIND_REGISTER, nm, 8'($urandom));
         known_names.push_back(nm);
      end
      send_name(KIND_REGISTER, known_names[0], 8'h77);
      random_name(nm, 2);
      send_name(KIND_REGISTER, nm, 8'h78);
      send_name(KIND_LOOKUP, known_names[$], 8'h00);
   endtask

   initial begin
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_data       = '0;
      rsp_ready      = 1'b0;
      error_count    = 0;
      idle_cycles    = 0;
      tbl_count      = 0;
      name_pos       = 0;
      name_overflow  = 1'b0;
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed();
      test_random(250);
      send_idle_pct  = 50;
      test_random(250);
      send_idle_pct  = 0;
      recv_stall_pct = 50;
      test_random(250);
      send_idle_pct  = 38;
      recv_stall_pct = 38;
      test_random(200);
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      test_full();
      wait_drained();

      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
